[hw/rtl/bsq_pkg.sv]
// Shared types, register map and constants of the battery sample qualifier.
package bsq_pkg;

    // Configuration port geometry.
    localparam int unsigned CfgAddrWidth = 5;
    localparam int unsigned CfgDataWidth = 32;
    localparam int unsigned CfgIdxWidth  = 3;

    // Register indexes (byte address is four times the index).
    localparam logic [CfgIdxWidth-1:0] REG_CHARGE_ON_CURRENT    = 3'd0;
    localparam logic [CfgIdxWidth-1:0] REG_CHARGE_CONFIRM_COUNT = 3'd1;
    localparam logic [CfgIdxWidth-1:0] REG_LOW_CHARGE_PERCENT   = 3'd2;
    localparam logic [CfgIdxWidth-1:0] REG_LOW_CONFIRM_COUNT    = 3'd3;
    localparam logic [CfgIdxWidth-1:0] REG_MIN_VALID_MV         = 3'd4;
    localparam logic [CfgIdxWidth-1:0] REG_MAX_VALID_MV         = 3'd5;

    // Register reset values.
    localparam logic [15:0] CHARGE_ON_CURRENT_RST    = 16'd8;
    localparam logic [7:0]  CHARGE_CONFIRM_COUNT_RST = 8'd3;
    localparam logic [6:0]  LOW_CHARGE_PERCENT_RST   = 7'd2;
    localparam logic [7:0]  LOW_CONFIRM_COUNT_RST    = 8'd3;
    localparam logic [15:0] MIN_VALID_MV_RST         = 16'd2500;
    localparam logic [15:0] MAX_VALID_MV_RST         = 16'd5000;

    // Largest percentage a gauge may report for charge or health.
    localparam logic [15:0] PERCENT_MAX = 16'd100;
    // Marker for "time not applicable" and "health invalid".
    localparam logic [15:0] FULL16      = 16'hFFFF;

    localparam int unsigned InDataWidth  = 136;
    localparam int unsigned OutDataWidth = 112;

    // Input item, first field in the lowest bits.
    typedef struct packed {
        logic [4:0]         pad;
        logic [15:0]        health_raw;
        logic [15:0]        cycles_in;
        logic [15:0]        full_minutes;
        logic [15:0]        empty_minutes;
        logic               discharge_flag;
        logic signed [15:0] average_current;
        logic signed [15:0] instant_current;
        logic [15:0]        charge_raw;
        logic [15:0]        gauge_mv;
        logic               force_req;
        logic               read_ok;
    } in_item_t;

    // Result item, first field in the lowest bits.
    typedef struct packed {
        logic [4:0]         pad;
        logic               shutdown_request;
        logic [15:0]        health_percent;
        logic [15:0]        cycle_total;
        logic [15:0]        to_full_minutes;
        logic [15:0]        to_empty_minutes;
        logic signed [15:0] reported_current;
        logic [15:0]        cell_mv;
        logic [6:0]         charge_percent;
        logic               charging;
        logic               available;
        logic               publish;
    } out_item_t;

    // Stored record of the last published sample.
    typedef struct packed {
        logic               valid;
        logic               charging;
        logic [6:0]         percent;
        logic [15:0]        voltage;
        logic signed [15:0] current;
        logic [15:0]        to_empty;
        logic [15:0]        to_full;
        logic [15:0]        cycles;
        logic [15:0]        health;
    } record_t;

endpackage

[hw/rtl/battery_sample_qualifier.sv]
// Top level of the battery sample qualifier: qualification, debounce and record logic.
//
// The block takes one fuel-gauge sample per transfer on the s_axis side and returns exactly
// one result transfer on the m_axis side for each. A sample is rejected when the read failed,
// the voltage lies outside the [min_valid_mv, max_valid_mv] window, or the charge exceeds
// 100 percent; a rejected sample leaves all state alone and returns the stored record with
// publish equal to force_req. A valid sample updates a debounced charging latch, is
// formatted into a record, and the record is stored and published when it changed, when
// none was held yet, or when forced. A low-charge counter raises shutdown_request once
// after reset. The whole step is a few compares and counter updates done in the cycle a
// transfer is accepted; the result lands in an output register, so one sample is taken
// every clock cycle and a result appears in the cycle after its sample. The only limit on
// rate is the output register: a new sample is taken whenever the register is empty or
// its result is being taken in the same cycle. Configuration is written through the APB
// port while no sample is in flight, a rule on the user that the block does not enforce.
module battery_sample_qualifier
    import bsq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    // Input: read_ok, force_req, gauge_mv, charge_raw, instant_current,
    // average_current, discharge_flag, empty_minutes, full_minutes, cycles_in,
    // health_raw, zero fill.
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [InDataWidth-1:0]  s_axis_tdata,

    // Output: publish, available, charging, charge_percent, cell_mv,
    // reported_current, to_empty_minutes, to_full_minutes, cycle_total,
    // health_percent, shutdown_request, zero fill.
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OutDataWidth-1:0] m_axis_tdata,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CfgAddrWidth-1:0] paddr,
    input  logic [CfgDataWidth-1:0] pwdata,
    output logic [CfgDataWidth-1:0] prdata,
    output logic                    pready
);

    // Configuration registers.
    logic [15:0] charge_on_current_reg;
    logic [7:0]  charge_confirm_count_reg;
    logic [6:0]  low_charge_percent_reg;
    logic [7:0]  low_confirm_count_reg;
    logic [15:0] min_valid_mv_reg;
    logic [15:0] max_valid_mv_reg;

    // Debounce and shutdown state.
    logic        charge_latch_reg,     charge_latch_next;
    logic        charge_candidate_reg, charge_candidate_next;
    logic [7:0]  candidate_run_reg,    candidate_run_next;
    logic [7:0]  low_run_reg,          low_run_next;
    logic        shutdown_sent_reg,    shutdown_sent_next;
    record_t     record_reg,           record_next;

    // Output register.
    logic        m_valid_reg;
    out_item_t   m_data_reg,           m_data_next;

    in_item_t    in_item;
    logic        in_xfer;
    logic        cfg_write;
    logic [CfgIdxWidth-1:0] cfg_idx;

    logic        sample_ok;
    logic        candidate;
    logic        publish;
    logic        shutdown_pulse;
    record_t     formatted;

    assign in_item       = in_item_t'(s_axis_tdata);
    // The output register either is empty or hands its result over in this cycle.
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OutDataWidth'(m_data_reg);

    // ---------------------------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[CfgAddrWidth-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charge_on_current_reg    <= CHARGE_ON_CURRENT_RST;
            charge_confirm_count_reg <= CHARGE_CONFIRM_COUNT_RST;
            low_charge_percent_reg   <= LOW_CHARGE_PERCENT_RST;
            low_confirm_count_reg    <= LOW_CONFIRM_COUNT_RST;
            min_valid_mv_reg         <= MIN_VALID_MV_RST;
            max_valid_mv_reg         <= MAX_VALID_MV_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_CHARGE_ON_CURRENT:    charge_on_current_reg    <= pwdata[15:0];
                REG_CHARGE_CONFIRM_COUNT: charge_confirm_count_reg <= pwdata[7:0];
                REG_LOW_CHARGE_PERCENT:   low_charge_percent_reg   <= pwdata[6:0];
                REG_LOW_CONFIRM_COUNT:    low_confirm_count_reg    <= pwdata[7:0];
                REG_MIN_VALID_MV:         min_valid_mv_reg         <= pwdata[15:0];
                REG_MAX_VALID_MV:         max_valid_mv_reg         <= pwdata[15:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_CHARGE_ON_CURRENT:    prdata = {16'd0, charge_on_current_reg};
            REG_CHARGE_CONFIRM_COUNT: prdata = {24'd0, charge_confirm_count_reg};
            REG_LOW_CHARGE_PERCENT:   prdata = {25'd0, low_charge_percent_reg};
            REG_LOW_CONFIRM_COUNT:    prdata = {24'd0, low_confirm_count_reg};
            REG_MIN_VALID_MV:         prdata = {16'd0, min_valid_mv_reg};
            REG_MAX_VALID_MV:         prdata = {16'd0, max_valid_mv_reg};
            default:                  prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------------------
    // Sample step
    // ---------------------------------------------------------------------------------
    always_comb
    begin
        sample_ok = in_item.read_ok
                 && (in_item.gauge_mv >= min_valid_mv_reg)
                 && (in_item.gauge_mv <= max_valid_mv_reg)
                 && (in_item.charge_raw <= PERCENT_MAX);

        // Charging looks likely if the gauge is not discharging or either current
        // reaches the on threshold.
        candidate = !in_item.discharge_flag
                 || ($signed(in_item.instant_current) >= $signed(charge_on_current_reg))
                 || ($signed(in_item.average_current) >= $signed(charge_on_current_reg));

        charge_candidate_next = charge_candidate_reg;
        candidate_run_next    = candidate_run_reg;
        charge_latch_next     = charge_latch_reg;
        low_run_next          = low_run_reg;
        shutdown_sent_next    = shutdown_sent_reg;
        record_next           = record_reg;
        shutdown_pulse        = 1'b0;
        publish               = in_item.force_req;

        if (sample_ok)
        begin
            if (candidate != charge_candidate_reg)
            begin
                charge_candidate_next = candidate;
                candidate_run_next    = 8'd1;
            end
            else if (candidate_run_reg < charge_confirm_count_reg)
            begin
                candidate_run_next = candidate_run_reg + 8'd1;
            end
            if (candidate_run_next >= charge_confirm_count_reg)
            begin
                charge_latch_next = candidate;
            end
        end

        formatted.valid    = 1'b1;
        formatted.charging = charge_latch_next;
        formatted.percent  = in_item.charge_raw[6:0];
        formatted.voltage  = in_item.gauge_mv;
        formatted.current  = in_item.average_current;
        formatted.to_empty = charge_latch_next ? FULL16 : in_item.empty_minutes;
        formatted.to_full  = charge_latch_next ? in_item.full_minutes : FULL16;
        formatted.cycles   = in_item.cycles_in;
        formatted.health   = (in_item.health_raw > PERCENT_MAX) ? FULL16
                                                                : in_item.health_raw;

        if (sample_ok)
        begin
            // A change in any field, including the first valid sample, publishes.
            if (formatted != record_reg)
            begin
                publish = 1'b1;
            end
            if (publish)
            begin
                record_next = formatted;
            end

            if (charge_latch_next || ({9'd0, low_charge_percent_reg} <= in_item.charge_raw))
            begin
                low_run_next = 8'd0;
            end
            else if (!shutdown_sent_reg)
            begin
                if (low_run_reg < low_confirm_count_reg)
                begin
                    low_run_next = low_run_reg + 8'd1;
                end
                if (low_run_next >= low_confirm_count_reg)
                begin
                    shutdown_sent_next = 1'b1;
                    shutdown_pulse     = 1'b1;
                end
            end
        end

        m_data_next.pad              = '0;
        m_data_next.publish          = publish;
        m_data_next.available        = record_next.valid;
        m_data_next.charging         = record_next.charging;
        m_data_next.charge_percent   = record_next.percent;
        m_data_next.cell_mv          = record_next.voltage;
        m_data_next.reported_current = record_next.current;
        m_data_next.to_empty_minutes = record_next.to_empty;
        m_data_next.to_full_minutes  = record_next.to_full;
        m_data_next.cycle_total      = record_next.cycles;
        m_data_next.health_percent   = record_next.health;
        m_data_next.shutdown_request = shutdown_pulse;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charge_latch_reg     <= 1'b0;
            charge_candidate_reg <= 1'b0;
            candidate_run_reg    <= '0;
            low_run_reg          <= '0;
            shutdown_sent_reg    <= 1'b0;
            record_reg           <= '0;
        end
        else if (in_xfer)
        begin
            charge_latch_reg     <= charge_latch_next;
            charge_candidate_reg <= charge_candidate_next;
            candidate_run_reg    <= candidate_run_next;
            low_run_reg          <= low_run_next;
            shutdown_sent_reg    <= shutdown_sent_next;
            record_reg           <= record_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            m_data_reg <= m_data_next;
        end
    end

    // ---------------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------------
    // Once requested, shutdown stays recorded until reset.
    a_shutdown_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        shutdown_sent_reg |=> shutdown_sent_reg)
        else $error("shutdown_sent cleared without reset");

    // A shutdown request comes only with a valid sample, so a record is held.
    a_shutdown_has_record: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg.shutdown_request) |-> m_data_reg.available)
        else $error("shutdown request without a valid record");

    // A shutdown request pulse is never seen with the flag already set beforehand.
    a_shutdown_once: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && shutdown_pulse) |-> !shutdown_sent_reg)
        else $error("second shutdown request");

    // A charging record always reports time to empty as not applicable.
    a_charging_format: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg.charging) |-> (m_data_reg.to_empty_minutes == FULL16))
        else $error("charging record with a time to empty");

    // An empty output register never holds off the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty output register");

endmodule
